[src/sdf_pkg.sv]
// ----------------------------------------------------------------------------
// sdf_pkg: shared definitions for the signed decimal formatter
// Field widths, ASCII codes and the records passed between the converter,
// the character emitter and the top level.
// ----------------------------------------------------------------------------
package sdf_pkg;

  // field widths
  localparam int VALUE_W    = 16;
  localparam int CHAR_W     = 6;

  // decimal digits held after conversion (magnitude never exceeds 32768)
  localparam int NUM_DIGITS = 5;
  localparam int DIGIT_W    = 4;
  localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
  localparam int IDX_W      = $clog2(NUM_DIGITS);

  // binary bits folded into the BCD register per cycle
  localparam int STEP_BITS  = 2;
  localparam int NUM_STEPS  = VALUE_W / STEP_BITS;
  localparam int STEP_CNT_W = $clog2(NUM_STEPS);

  // ASCII codes, low six bits
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [BCD_W-1:0]   bcd_t;

  // converter result toward the top level
  typedef struct packed {
    logic done;
    bcd_t bcd;
  } bcd_result_t;

  // load command for the character emitter
  typedef struct packed {
    logic load;
    logic neg;
    bcd_t bcd;
  } emit_load_t;

endpackage

[src/sdf_if.sv]
// ----------------------------------------------------------------------------
// sdf_value_if / sdf_char_if: valid-ready channels of the formatter
// One beat moves when valid and ready are both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface sdf_value_if import sdf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sdf_char_if import sdf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

[src/sdf_bcd.sv]
// ----------------------------------------------------------------------------
// sdf_bcd: serial binary to BCD converter
// Shift-and-add-3 conversion, two magnitude bits per cycle.
// ----------------------------------------------------------------------------
module sdf_bcd import sdf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [VALUE_W-1:0] mag,
  output bcd_result_t        result
);

  logic [VALUE_W-1:0]    mag_sr;
  bcd_t                  bcd;
  logic [STEP_CNT_W-1:0] cnt;
  logic                  busy;
  logic                  done;
  bcd_t                  bcd_next;

  // one dabble step: correct digits of five or more, then shift a bit in
  function automatic bcd_t dabble(input bcd_t b, input logic bit_in);
    bcd_t adj;
    adj = b;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (adj[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
        adj[i*DIGIT_W +: DIGIT_W] = adj[i*DIGIT_W +: DIGIT_W] + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], bit_in};
  endfunction

  // fold the top bits of the shift register in, msb first
  always_comb begin
    bcd_next = bcd;
    for (int s = 0; s < STEP_BITS; s++) begin
      bcd_next = dabble(bcd_next, mag_sr[VALUE_W-1-s]);
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == STEP_CNT_W'(NUM_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      mag_sr <= mag;
      bcd    <= '0;
    end else if (busy) begin
      mag_sr <= {mag_sr[VALUE_W-1-STEP_BITS:0], {STEP_BITS{1'b0}}};
      bcd    <= bcd_next;
    end
  end

  assign result.done = done;
  assign result.bcd  = bcd;

endmodule

[src/sdf_emit.sv]
// ----------------------------------------------------------------------------
// sdf_emit: character emitter
// Holds the sign and the BCD digits and sends one ASCII character per beat,
// a minus sign first for a negative value, then digits from the highest nonzero one down.
// ----------------------------------------------------------------------------
module sdf_emit import sdf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  emit_load_t cmd,
  output logic       finished,
  sdf_char_if.source char_ch
);

  digit_t           digits [NUM_DIGITS];
  logic             neg_pend;
  logic [IDX_W-1:0] idx;
  logic             active;
  logic             beat;
  logic             is_last;

  // index of the highest nonzero digit, zero when all digits are zero
  function automatic logic [IDX_W-1:0] top_index(input bcd_t b);
    logic [IDX_W-1:0] t;
    t = '0;
    for (int i = 1; i < NUM_DIGITS; i++) begin
      if (b[i*DIGIT_W +: DIGIT_W] != '0) t = IDX_W'(i);
    end
    return t;
  endfunction

  assign beat     = char_ch.valid && char_ch.ready;
  assign is_last  = !neg_pend && (idx == '0);
  assign finished = beat && is_last;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      neg_pend <= 1'b0;
      idx      <= '0;
    end else if (cmd.load) begin
      active   <= 1'b1;
      neg_pend <= cmd.neg;
      idx      <= top_index(cmd.bcd);
    end else if (beat) begin
      if (neg_pend) begin
        neg_pend <= 1'b0;
      end else if (idx == '0) begin
        active <= 1'b0;
      end else begin
        idx <= idx - 1'b1;
      end
    end
  end

  // digit store
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        digits[i] <= cmd.bcd[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  // output beat
  assign char_ch.valid     = active;
  assign char_ch.last      = is_last;
  assign char_ch.character = neg_pend ? CHAR_MINUS
                                      : CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digits[idx]};

endmodule

[src/signed_decimal_formatter_core.sv]
// ----------------------------------------------------------------------------
// signed_decimal_formatter_core: signed 16-bit integer to decimal ASCII text
// The input beat starts a two-bit-per-cycle BCD conversion; its result then
// loads the emitter, which sends one character per cycle while the output
// is ready. One value is in flight at a time: a new value is taken only
// after the last character of the previous one. Synchronous reset returns
// the block to idle.
// ----------------------------------------------------------------------------
module signed_decimal_formatter_core import sdf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  sdf_value_if.sink  value_ch,
  sdf_char_if.source char_ch
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t             state;
  state_t             state_next;
  logic               accept;
  logic               neg;
  logic [VALUE_W-1:0] mag;
  logic               finished;
  bcd_result_t        conv;
  emit_load_t         cmd;

  assign value_ch.ready = (state == ST_IDLE);
  assign accept         = value_ch.valid && value_ch.ready;

  // magnitude in 16 unsigned bits; the most negative value maps to 0x8000
  assign mag = value_ch.value[VALUE_W-1] ? (~value_ch.value + 1'b1) : value_ch.value;

  // sign kept for the emitter
  always_ff @(posedge clk) begin
    if (accept) neg <= value_ch.value[VALUE_W-1];
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept)    state_next = ST_CONV;
      ST_CONV: if (conv.done) state_next = ST_EMIT;
      ST_EMIT: if (finished)  state_next = ST_IDLE;
      default:                state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  assign cmd.load = conv.done;
  assign cmd.neg  = neg;
  assign cmd.bcd  = conv.bcd;

  sdf_bcd u_bcd (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .mag    (mag),
    .result (conv)
  );

  sdf_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .finished (finished),
    .char_ch  (char_ch)
  );

endmodule
